@@ sv/gmtc_pkg.sv @@
// ----------------------------------------------------------------------------
// gmtc_pkg
// Shared types and constants for the grid step-limit search block.
// ----------------------------------------------------------------------------
package gmtc_pkg;
    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int CELL_CAP  = MAX_ROWS * MAX_COLS;
    localparam int AW        = $clog2(CELL_CAP);
    localparam int HW        = 30;
    localparam int CW        = 7;
    localparam int RW        = $clog2(MAX_ROWS + 1);
    localparam int KW        = $clog2(MAX_COLS + 1);
    localparam int DCW       = $clog2(AW);
    localparam logic [HW-1:0] H_MASK = {HW{1'b1}};
    localparam logic [0:0] REG_ROWS = 1'b0;
    localparam logic [0:0] REG_COLS = 1'b1;

    typedef enum logic [4:0] {
        S_LOAD,
        S_FIND,      // scan waypoint map for the first waypoint
        S_FIND_W,
        S_TRIAL,     // clear visited map
        S_SEED,
        S_POP,       // read top of stack
        S_POP_W,
        S_CUR,       // read current height
        S_CUR_W,
        S_DIV,       // split cell index into row and column
        S_NB,        // read neighbour height and visited bit
        S_NB_W,
        S_NB_CHK,
        S_CHK,       // scan waypoints against visited map
        S_CHK_W,
        S_DECIDE,
        S_OUT
    } t_state;
endpackage

@@ sv/gmtc_ram.sv @@
// ----------------------------------------------------------------------------
// gmtc_ram
// Single-port-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module gmtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ sv/grid_min_threshold_connectivity.sv @@
// ----------------------------------------------------------------------------
// grid_min_threshold_connectivity
// Least step limit that joins every waypoint of a loaded height grid.
// Sequence: the last loaded cell starts a first-waypoint scan and a binary search of
//   up to log2(max-min)+1 trials. Each trial clears the visited map, fills (per visited
//   cell: pop, height read, a 12-step row/column split, up to four neighbour probes)
//   and scans the waypoints against the visited map.
// Throughput: one cell per cycle while loading; one grid at a time while searching.
// Reset: synchronous, active low; resets control and statistics, sets configuration to the maximum grid.
// ----------------------------------------------------------------------------
module grid_min_threshold_connectivity
    import gmtc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [HW-1:0] i_cell_height,
    input  logic          i_is_waypoint,
    input  logic          i_last_cell,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [HW-1:0] o_min_step_limit,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_index,
    input  logic [CW-1:0] i_cfg_data
);
    t_state r_state, n_state;

    logic [CW-1:0] r_rows, r_cols;
    logic [RW-1:0] rows_e;
    logic [KW-1:0] cols_e;
    logic [AW:0]   total;

    logic [AW:0]   r_lpos;
    logic [HW-1:0] r_hmin, r_hmax;
    logic [HW-1:0] r_lo, r_best, r_trial;
    logic [HW:0]   r_hi;
    logic          r_found;
    logic [AW-1:0] r_start;
    logic [AW:0]   r_idx;      // scan counter
    logic [AW:0]   r_sp;
    logic [AW-1:0] r_cur;
    logic [KW-1:0] r_ccol;
    logic [RW-1:0] r_crow;
    logic [HW-1:0] r_ch;
    logic [1:0]    r_dir;
    logic [AW-1:0] r_nb;
    logic [HW-1:0] r_res;
    logic [AW-1:0] r_dq;       // dividend shifting out, quotient shifting in
    logic [KW-1:0] r_drem;
    logic [DCW-1:0] r_dcnt;

    // memory ports
    logic          h_we, w_we, v_we, s_we;
    logic [AW-1:0] h_wa, h_ra, w_wa, w_ra, v_wa, v_ra, s_wa, s_ra;
    logic [HW-1:0] h_wd, h_rd;
    logic          w_wd, w_rd, v_wd, v_rd;
    logic [AW-1:0] s_wd, s_rd;

    gmtc_ram #(.WIDTH(HW), .DEPTH(CELL_CAP)) u_height (
        .i_clk, .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd), .i_raddr(h_ra), .o_rdata(h_rd));
    gmtc_ram #(.WIDTH(1), .DEPTH(CELL_CAP)) u_wayp (
        .i_clk, .i_we(w_we), .i_waddr(w_wa), .i_wdata(w_wd), .i_raddr(w_ra), .o_rdata(w_rd));
    gmtc_ram #(.WIDTH(1), .DEPTH(CELL_CAP)) u_visit (
        .i_clk, .i_we(v_we), .i_waddr(v_wa), .i_wdata(v_wd), .i_raddr(v_ra), .o_rdata(v_rd));
    gmtc_ram #(.WIDTH(AW), .DEPTH(CELL_CAP)) u_stack (
        .i_clk, .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd), .i_raddr(s_ra), .o_rdata(s_rd));

    // Effective grid size: zero counts as one, clamp to the maximum.
    always_comb begin
        if (r_rows == '0)                 rows_e = RW'(1);
        else if (r_rows > CW'(MAX_ROWS))  rows_e = RW'(MAX_ROWS);
        else                              rows_e = RW'(r_rows);
        if (r_cols == '0)                 cols_e = KW'(1);
        else if (r_cols > CW'(MAX_COLS))  cols_e = KW'(MAX_COLS);
        else                              cols_e = KW'(r_cols);
    end
    assign total = (AW+1)'(rows_e) * (AW+1)'(cols_e);

    logic acc_in, acc_out, store_ok;
    assign acc_in   = i_valid && !o_stall;
    assign acc_out  = o_valid && !i_stall;
    assign o_stall  = (r_state != S_LOAD);
    assign o_valid  = (r_state == S_OUT);
    assign o_min_step_limit = r_res;
    assign store_ok = (r_lpos < total);

    // One restoring step of the index-by-column-count division.
    logic [KW:0]   div_part;
    logic          div_ge;
    logic [KW-1:0] div_rem;
    assign div_part = {r_drem, r_dq[AW-1]};
    assign div_ge   = (div_part >= {1'b0, cols_e});
    assign div_rem  = div_ge ? KW'(div_part - {1'b0, cols_e}) : div_part[KW-1:0];

    // Neighbour selection: right, left, up, down.
    logic          nb_ok;
    logic [AW-1:0] nb_addr;
    always_comb begin
        nb_ok   = 1'b0;
        nb_addr = r_cur;
        case (r_dir)
            2'd0: begin nb_ok = (r_ccol + 1'b1 < cols_e); nb_addr = r_cur + 1'b1; end
            2'd1: begin nb_ok = (r_ccol != '0); nb_addr = r_cur - 1'b1; end
            2'd2: begin nb_ok = (r_crow != '0); nb_addr = r_cur - AW'(cols_e); end
            2'd3: begin nb_ok = (r_crow + 1'b1 < rows_e); nb_addr = r_cur + AW'(cols_e); end
            default: ;
        endcase
    end

    logic [HW-1:0] diff;
    logic          join_ok, trial_ok, range_done;
    assign diff     = (h_rd > r_ch) ? h_rd - r_ch : r_ch - h_rd;
    assign join_ok  = !v_rd && (diff <= r_trial) && (r_sp < (AW+1)'(CELL_CAP));
    assign range_done = ({1'b0, r_lo} > r_hi);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:   if (acc_in && i_last_cell) n_state = S_FIND;
            S_FIND:   n_state = (r_idx >= total) ? S_OUT : S_FIND_W;
            S_FIND_W: n_state = w_rd ? S_TRIAL : S_FIND;
            S_TRIAL:  if (r_idx + 1'b1 >= total) n_state = S_SEED;
            S_SEED:   n_state = S_POP;
            S_POP:    n_state = (r_sp == '0) ? S_CHK : S_POP_W;
            S_POP_W:  n_state = S_CUR;
            S_CUR:    n_state = S_CUR_W;
            S_CUR_W:  n_state = S_DIV;
            S_DIV:    if (r_dcnt == DCW'(AW-1)) n_state = S_NB;
            S_NB:     n_state = nb_ok ? S_NB_W : ((r_dir == 2'd3) ? S_POP : S_NB);
            S_NB_W:   n_state = S_NB_CHK;
            S_NB_CHK: n_state = (r_dir == 2'd3) ? S_POP : S_NB;
            S_CHK:    n_state = (r_idx >= total) ? S_DECIDE : S_CHK_W;
            S_CHK_W:  n_state = (w_rd && !v_rd) ? S_DECIDE : S_CHK;
            S_DECIDE: n_state = S_TRIAL;
            S_OUT:    if (acc_out) n_state = S_LOAD;
            default:  n_state = S_LOAD;
        endcase
        if (r_state == S_DECIDE) begin
            // trial passes when the check scan ran to the end
            if (r_idx >= total) begin
                if (r_trial == '0 || ({1'b0, r_lo} > {1'b0, r_trial} - 1'b1)) n_state = S_OUT;
            end else if (r_trial + 1'b1 > r_hi[HW-1:0] || r_hi[HW]) begin
                if ({1'b0, r_trial} + 1'b1 > r_hi) n_state = S_OUT;
            end
        end
        if (r_state == S_TRIAL && range_done) n_state = S_OUT;
    end

    // Memory port control.
    always_comb begin
        h_we = 1'b0; h_wa = r_lpos[AW-1:0]; h_wd = i_cell_height; h_ra = r_cur;
        w_we = 1'b0; w_wa = r_lpos[AW-1:0]; w_wd = i_is_waypoint; w_ra = r_idx[AW-1:0];
        v_we = 1'b0; v_wa = r_idx[AW-1:0];  v_wd = 1'b0;          v_ra = r_idx[AW-1:0];
        s_we = 1'b0; s_wa = r_sp[AW-1:0];   s_wd = r_start;       s_ra = r_sp[AW-1:0] - 1'b1;
        case (r_state)
            S_LOAD: begin
                h_we = acc_in && store_ok;
                w_we = acc_in && store_ok;
            end
            S_TRIAL: v_we = !range_done;
            S_SEED: begin
                v_we = 1'b1; v_wa = r_start; v_wd = 1'b1;
                s_we = 1'b1; s_wa = '0;
            end
            S_NB: begin
                h_ra = nb_addr;
                v_ra = nb_addr;
            end
            S_NB_W: begin
                // hold the neighbour address so its data is still there at the check
                h_ra = r_nb;
                v_ra = r_nb;
            end
            S_NB_CHK: begin
                h_ra = r_nb;
                v_we = join_ok; v_wa = r_nb; v_wd = 1'b1;
                s_we = join_ok; s_wd = r_nb;
            end
            default: ;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_rows  <= CW'(MAX_ROWS);
            r_cols  <= CW'(MAX_COLS);
            r_lpos  <= '0;
            r_hmin  <= H_MASK;
            r_hmax  <= '0;
            r_idx   <= '0;
            r_sp    <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_ROWS) r_rows <= i_cfg_data;
                else                         r_cols <= i_cfg_data;
            end
            case (r_state)
                S_LOAD: begin
                    r_idx <= '0;
                    if (acc_in && store_ok) begin
                        r_lpos <= r_lpos + 1'b1;
                        if (i_cell_height < r_hmin) r_hmin <= i_cell_height;
                        if (i_cell_height > r_hmax) r_hmax <= i_cell_height;
                    end
                    if (acc_in && i_last_cell) begin
                        r_res   <= '0;
                        r_found <= 1'b0;
                    end
                end
                S_FIND: if (r_idx >= total) r_res <= '0;
                S_FIND_W: begin
                    if (w_rd) begin
                        r_start <= r_idx[AW-1:0];
                        r_lo    <= '0;
                        r_hi    <= {1'b0, ((r_hmax >= r_hmin) ? r_hmax - r_hmin : HW'(0))};
                        r_best  <= '0;
                        r_idx   <= '0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_TRIAL: begin
                    r_trial <= HW'(({1'b0, r_lo} + r_hi) >> 1);
                    r_idx   <= (r_idx + 1'b1 >= total) ? '0 : r_idx + 1'b1;
                    if (range_done) r_res <= r_found ? r_best : H_MASK;
                end
                S_SEED: r_sp <= (AW+1)'(1);
                S_POP: if (r_sp != '0) r_sp <= r_sp - 1'b1;
                S_POP_W: r_cur <= s_rd;
                S_CUR: begin
                    r_dq   <= r_cur;
                    r_drem <= '0;
                    r_dcnt <= '0;
                    r_dir  <= 2'd0;
                end
                S_CUR_W: r_ch <= h_rd;
                S_DIV: begin
                    r_dq   <= {r_dq[AW-2:0], div_ge};
                    r_drem <= div_rem;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DCW'(AW-1)) begin
                        r_ccol <= div_rem;
                        r_crow <= RW'({r_dq[AW-2:0], div_ge});
                    end
                end
                S_NB: begin
                    r_nb <= nb_addr;
                    if (!nb_ok) r_dir <= r_dir + 1'b1;
                end
                S_NB_CHK: begin
                    if (join_ok) r_sp <= r_sp + 1'b1;
                    r_dir <= r_dir + 1'b1;
                end
                S_CHK: if (r_idx < total) r_idx <= r_idx;
                S_CHK_W: if (!(w_rd && !v_rd)) r_idx <= r_idx + 1'b1;
                S_DECIDE: begin
                    r_idx <= '0;
                    if (r_idx >= total) begin
                        r_best  <= r_trial;
                        r_found <= 1'b1;
                        if (r_trial == '0) begin
                            r_res <= r_trial;
                            r_lo  <= HW'(1);
                            r_hi  <= '0;
                        end else begin
                            r_hi <= {1'b0, r_trial} - 1'b1;
                            if ({1'b0, r_lo} > {1'b0, r_trial} - 1'b1) r_res <= r_trial;
                        end
                    end else begin
                        r_lo <= r_trial + 1'b1;
                        if ({1'b0, r_trial} + 1'b1 > r_hi) r_res <= r_found ? r_best : H_MASK;
                    end
                end
                S_OUT: if (acc_out) begin
                    r_lpos <= '0;
                    r_hmin <= H_MASK;
                    r_hmax <= '0;
                end
                default: ;
            endcase
        end
    end

    // Check scan reads waypoint and visited at the same index.
    // (v_ra and w_ra both follow r_idx outside the fill.)

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !acc_in) else $error("input taken while searching");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_res))) else $error("result dropped");
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= (AW+1)'(CELL_CAP)) else $error("stack overflow");
    a_lpos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lpos <= (AW+1)'(CELL_CAP)) else $error("load position overrun");
endmodule
